/* design/gdau_pkg.sv */
// Package for the Gregorian date arithmetic unit: opcodes, status codes,
// FSM state type, datapath widths, divider reciprocals and the month tables.
// No dependencies.
package gdau_pkg;

  localparam int MAX_YEAR_DEF = 9999;
  localparam int TOTAL_MAX    = 4194303;

  // serial width (signed), divider dividend/divisor widths
  localparam int SW        = 28;
  localparam int DIV_W     = 25;
  localparam int DVS_W     = 18;
  // reciprocal divider: multiply, back-multiply, correct
  localparam int DIV_STEPS = 3;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int RCP_W     = 23;
  localparam int RCP_SH    = DIV_W;

  localparam logic [RCP_W-1:0] RCP_7      = RCP_W'((1 << RCP_SH) / 7);
  localparam logic [RCP_W-1:0] RCP_100    = RCP_W'((1 << RCP_SH) / 100);
  localparam logic [RCP_W-1:0] RCP_365    = RCP_W'((1 << RCP_SH) / 365);
  localparam logic [RCP_W-1:0] RCP_1460   = RCP_W'((1 << RCP_SH) / 1460);
  localparam logic [RCP_W-1:0] RCP_36524  = RCP_W'((1 << RCP_SH) / 36524);
  localparam logic [RCP_W-1:0] RCP_146097 = RCP_W'((1 << RCP_SH) / 146097);

  localparam int SERIAL_LO = -60;  // serial of 1.1.0

  localparam logic [3:0] OP_VALIDATE = 4'd0;
  localparam logic [3:0] OP_NEXT     = 4'd1;
  localparam logic [3:0] OP_PREV     = 4'd2;
  localparam logic [3:0] OP_ADD      = 4'd3;
  localparam logic [3:0] OP_SUB      = 4'd4;
  localparam logic [3:0] OP_EARLIER  = 4'd5;
  localparam logic [3:0] OP_DIFF     = 4'd6;
  localparam logic [3:0] OP_ORDINAL  = 4'd7;
  localparam logic [3:0] OP_ADDDATES = 4'd8;
  localparam logic [3:0] OP_SUBDATES = 4'd9;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_Y1, S_Y2, S_CHK, S_WD, S_RNG, S_ERA, S_A, S_B, S_YOE, S_C, S_MD, S_OUT
  } state_e;

  // day of year (from March 1) at which month index mp starts, mp 0 = March
  localparam logic [8:0] MSTART [12] = '{9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
                                         9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337};

  // month lengths, January first, non-leap
  localparam logic [4:0] MDAYS [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

endpackage

/* design/gregorian_date_arithmetic_unit.sv */
// Gregorian date arithmetic unit, top level.
// Depends on gdau_pkg.
//
// One item in, one result item out. Dates become day serials (1.3.0 = 0)
// and back, all through one shared divider that handles every division by a
// constant with a reciprocal multiply, a back-multiply for the remainder and
// one correction step on a single 25x23 multiplier. An item needs one
// division per input date, one more for the weekday if its dates are valid,
// and five more to turn a result serial back into a date. The input is not
// ready until the result item is taken.
module gregorian_date_arithmetic_unit
  import gdau_pkg::*;
#(
  parameter int MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: first_day[4:0] first_month[8:5] first_year[22:9] second_day[27:23]
  //        second_month[31:28] second_year[45:32] day_offset[68:46], zero pad
  input  logic [71:0] s_axis_tdata,
  // tuser: operation[3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: result_day[4:0] result_month[8:5] result_year[22:9]
  //        day_total[44:23] weekday[47:45]
  output logic [47:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser
);

  localparam int SH_HI   = MAX_YEAR + 400;
  localparam int HI_INT  = 365 * MAX_YEAR + SH_HI / 4 - SH_HI / 100 + SH_HI / 400 - 97 + 305;
  localparam logic signed [SW-1:0] SER_HI = SW'(HI_INT);
  localparam logic signed [SW-1:0] SER_LO = SW'(SERIAL_LO);
  localparam logic [16:0] MAXY = 17'(MAX_YEAR);

  state_e state_q, state_d;

  // shared divider
  logic [DIV_W-1:0] dx_q, dx_d;
  logic [DIV_W-1:0] dq_q, dq_d;
  logic [DIV_W-1:0] dr_q, dr_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [RCP_W-1:0] rcp_q, rcp_d;
  logic [CNT_W-1:0] dcnt_q, dcnt_d;
  logic             div_ld;
  logic [DIV_W-1:0] div_dnd;
  logic [DVS_W-1:0] div_dvs;
  logic [RCP_W-1:0] div_rcp;
  logic             div_done;
  logic [DIV_W-1:0] mul_a;
  logic [RCP_W-1:0] mul_b;
  logic [DIV_W+RCP_W-1:0] mul_p;

  // item registers
  logic [3:0]  op_q, op_d;
  logic [4:0]  d1_q, d1_d, d2_q, d2_d;
  logic [3:0]  m1_q, m1_d, m2_q, m2_d;
  logic [13:0] y1_q, y1_d, y2_q, y2_d;
  logic [22:0] off_q, off_d;
  logic signed [SW-1:0] s1_q, s1_d, s2_q, s2_d, res_q, res_d;
  logic        v1_q, v1_d, v2_q, v2_d;
  logic [7:0]  era_q, era_d;
  logic [17:0] doe_q, doe_d;
  logic [6:0]  a_q, a_d;
  logic [17:0] yoe_q, yoe_d;
  logic [8:0]  doy_q, doy_d;

  logic [4:0]  rday_q, rday_d;
  logic [3:0]  rmon_q, rmon_d;
  logic [13:0] ryear_q, ryear_d;
  logic [21:0] tot_q, tot_d;
  logic [2:0]  wday_q, wday_d;
  logic [1:0]  stat_q, stat_d;

  logic two, has_date;

  function automatic logic is_leap(input logic [13:0] y, input logic [7:0] q,
                                   input logic [6:0] r);
    logic res;
    res = (r == 7'd0) ? (q[1:0] == 2'd0) : (y[1:0] == 2'd0);
    return res;
  endfunction

  function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m,
                                   input logic [13:0] y, input logic [7:0] q,
                                   input logic [6:0] r, input logic [16:0] maxy);
    logic [4:0] lim;
    logic       ok;
    ok  = 1'b0;
    lim = 5'd0;
    if ({3'd0, y} <= maxy && m >= 4'd1 && m <= 4'd12) begin
      lim = MDAYS[m - 4'd1];
      if (m == 4'd2 && is_leap(y, q, r)) lim = 5'd29;
      ok = (d >= 5'd1) && (d <= lim);
    end
    return ok;
  endfunction

  // q and r are y / 100 and y % 100
  function automatic logic signed [SW-1:0] serial_of(input logic [4:0] d,
                                                     input logic [3:0] m,
                                                     input logic [13:0] y,
                                                     input logic [7:0] q,
                                                     input logic [6:0] r);
    logic                 early;
    logic [3:0]           mm;
    logic signed [SW-1:0] yy, sh4, h, acc;
    early = (m == 4'd1) || (m == 4'd2);
    mm    = 4'd0;
    if (m == 4'd1) mm = 4'd10;
    else if (m == 4'd2) mm = 4'd11;
    else if (m >= 4'd3 && m <= 4'd12) mm = m - 4'd3;
    yy  = SW'({14'd0, y}) - SW'({27'd0, early});
    sh4 = (SW'({14'd0, y}) + SW'(400) - SW'({27'd0, early})) >>> 2;
    // sh / 100 from y / 100: sh = y + 400 - early
    h   = SW'({20'd0, q}) + ((early && r == 7'd0) ? SW'(3) : SW'(4));
    acc = yy * SW'(365) + sh4 - h + (h >>> 2) - SW'(97)
        + SW'({19'd0, MSTART[mm]}) + SW'({23'd0, d}) - SW'(1);
    return acc;
  endfunction

  function automatic logic [21:0] sat_total(input logic signed [SW-1:0] v);
    logic [21:0] t;
    if (v < 0) t = 22'd0;
    else if (v > SW'(TOTAL_MAX)) t = 22'(TOTAL_MAX);
    else t = v[21:0];
    return t;
  endfunction

  always_comb begin
    two      = (op_q == OP_EARLIER) || (op_q == OP_DIFF) ||
               (op_q == OP_ADDDATES) || (op_q == OP_SUBDATES);
    has_date = (op_q inside {[OP_NEXT:OP_EARLIER], OP_ADDDATES, OP_SUBDATES});
  end

  assign div_done = (dcnt_q == '0);

  // one multiplier: x * reciprocal first, then quotient * divisor
  always_comb begin
    mul_a = dx_q;
    mul_b = rcp_q;
    if (dcnt_q == CNT_W'(2)) begin
      mul_a = dq_q;
      mul_b = RCP_W'(dvs_q);
    end
  end
  assign mul_p = mul_a * mul_b;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_Y1;
      S_Y1:   if (div_done) state_d = two ? S_Y2 : S_CHK;
      S_Y2:   if (div_done) state_d = S_CHK;
      S_CHK:  state_d = (!v1_q || (two && !v2_q)) ? S_OUT : S_WD;
      S_WD:   if (div_done) state_d = has_date ? S_RNG : S_OUT;
      S_RNG:  state_d = (res_q < SER_LO || res_q > SER_HI) ? S_OUT : S_ERA;
      S_ERA:  if (div_done) state_d = S_A;
      S_A:    if (div_done) state_d = S_B;
      S_B:    if (div_done) state_d = S_YOE;
      S_YOE:  if (div_done) state_d = S_C;
      S_C:    if (div_done) state_d = S_MD;
      S_MD:   state_d = S_OUT;
      S_OUT:  if (m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and divider operand selection
  always_comb begin
    logic signed [SW-1:0] smin, smax, offs;
    logic [2:0]  b;
    logic [17:0] n;
    logic [1:0]  c;
    logic [17:0] doy_w;
    logic [3:0]  mp;
    logic [3:0]  mon;
    logic [16:0] yr;
    op_d = op_q; d1_d = d1_q; m1_d = m1_q; y1_d = y1_q;
    d2_d = d2_q; m2_d = m2_q; y2_d = y2_q; off_d = off_q;
    s1_d = s1_q; s2_d = s2_q; v1_d = v1_q; v2_d = v2_q; res_d = res_q;
    era_d = era_q; doe_d = doe_q; a_d = a_q; yoe_d = yoe_q; doy_d = doy_q;
    rday_d = rday_q; rmon_d = rmon_q; ryear_d = ryear_q;
    tot_d = tot_q; wday_d = wday_q; stat_d = stat_q;
    div_ld  = 1'b0;
    div_dnd = '0;
    div_dvs = '0;
    div_rcp = '0;
    smin = (two && s2_q < s1_q) ? s2_q : s1_q;
    smax = (two && s2_q > s1_q) ? s2_q : s1_q;
    offs = SW'({5'd0, off_q});
    b = dq_q[2:0];
    n = doe_q - {11'd0, a_q} + {15'd0, b} - {17'd0, (doe_q == 18'd146096)};
    c = dq_q[1:0];
    doy_w = doe_q - 18'(yoe_q * 18'd365) - (yoe_q >> 2) + {16'd0, c};
    mp = 4'd0;
    for (int k = 0; k < 12; k++) begin
      if (doy_q >= MSTART[k]) mp = 4'(k);
    end
    mon = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    yr  = 17'(yoe_q) + 17'(era_q) * 17'd400 - 17'd400 + {16'd0, (mon <= 4'd2)};

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d  = s_axis_tuser;
          d1_d  = s_axis_tdata[4:0];
          m1_d  = s_axis_tdata[8:5];
          y1_d  = s_axis_tdata[22:9];
          d2_d  = s_axis_tdata[27:23];
          m2_d  = s_axis_tdata[31:28];
          y2_d  = s_axis_tdata[45:32];
          off_d = s_axis_tdata[68] ? 23'(-s_axis_tdata[68:46]) : s_axis_tdata[68:46];
          div_ld  = 1'b1;
          div_dnd = DIV_W'(s_axis_tdata[22:9]);
          div_dvs = DVS_W'(100);
          div_rcp = RCP_100;
        end
      end
      S_Y1: begin
        if (div_done) begin
          v1_d = date_ok(d1_q, m1_q, y1_q, dq_q[7:0], dr_q[6:0], MAXY);
          s1_d = serial_of(d1_q, m1_q, y1_q, dq_q[7:0], dr_q[6:0]);
          v2_d = 1'b1;
          if (two) begin
            div_ld  = 1'b1;
            div_dnd = DIV_W'(y2_q);
            div_dvs = DVS_W'(100);
            div_rcp = RCP_100;
          end
        end
      end
      S_Y2: begin
        if (div_done) begin
          v2_d = date_ok(d2_q, m2_q, y2_q, dq_q[7:0], dr_q[6:0], MAXY);
          s2_d = serial_of(d2_q, m2_q, y2_q, dq_q[7:0], dr_q[6:0]);
        end
      end
      S_CHK: begin
        rday_d = '0; rmon_d = '0; ryear_d = '0; tot_d = '0; wday_d = '0;
        if (!v1_q || (two && !v2_q)) begin
          stat_d = ST_INVALID;
        end else begin
          stat_d  = ST_OK;
          div_ld  = 1'b1;
          div_dnd = 25'(s1_q + SW'(65));  // keeps the weekday dividend positive
          div_dvs = DVS_W'(7);
          div_rcp = RCP_7;
        end
      end
      S_WD: begin
        if (div_done) begin
          wday_d = dr_q[2:0];
          case (op_q)
            OP_NEXT:     res_d = s1_q + SW'(1);
            OP_PREV:     res_d = s1_q - SW'(1);
            OP_ADD:      res_d = s1_q + offs;
            OP_SUB:      res_d = s1_q - offs;
            OP_EARLIER:  res_d = smin;
            OP_ADDDATES: res_d = smax + smin + SW'(61);
            OP_SUBDATES: res_d = smax - smin - SW'(61);
            default:     res_d = s1_q;
          endcase
          if (op_q == OP_DIFF) tot_d = sat_total(smax - smin);
          else if (op_q == OP_ORDINAL) tot_d = sat_total(s1_q + SW'(61));
        end
      end
      S_RNG: begin
        if (res_q < SER_LO || res_q > SER_HI) begin
          stat_d = ST_RANGE;
        end else begin
          div_ld  = 1'b1;
          div_dnd = 25'(res_q + SW'(146097));
          div_dvs = DVS_W'(146097);
          div_rcp = RCP_146097;
        end
      end
      S_ERA: begin
        if (div_done) begin
          era_d   = dq_q[7:0];
          doe_d   = dr_q[17:0];
          div_ld  = 1'b1;
          div_dnd = DIV_W'(dr_q[17:0]);
          div_dvs = DVS_W'(1460);
          div_rcp = RCP_1460;
        end
      end
      S_A: begin
        if (div_done) begin
          a_d     = dq_q[6:0];
          div_ld  = 1'b1;
          div_dnd = DIV_W'(doe_q);
          div_dvs = DVS_W'(36524);
          div_rcp = RCP_36524;
        end
      end
      S_B: begin
        if (div_done) begin
          div_ld  = 1'b1;
          div_dnd = DIV_W'(n);
          div_dvs = DVS_W'(365);
          div_rcp = RCP_365;
        end
      end
      S_YOE: begin
        if (div_done) begin
          yoe_d   = 18'(dq_q[8:0]);
          div_ld  = 1'b1;
          div_dnd = DIV_W'(dq_q[8:0]);
          div_dvs = DVS_W'(100);
          div_rcp = RCP_100;
        end
      end
      S_C: begin
        if (div_done) doy_d = doy_w[8:0];
      end
      S_MD: begin
        rday_d  = 5'(doy_q - MSTART[mp] + 9'd1);
        rmon_d  = mon;
        ryear_d = yr[13:0];
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // divider next values: quotient estimate is low by at most one
  always_comb begin
    dx_d   = dx_q;
    dq_d   = dq_q;
    dr_d   = dr_q;
    dvs_d  = dvs_q;
    rcp_d  = rcp_q;
    dcnt_d = dcnt_q;
    if (div_ld) begin
      dx_d   = div_dnd;
      dvs_d  = div_dvs;
      rcp_d  = div_rcp;
      dcnt_d = CNT_W'(DIV_STEPS);
    end else if (!div_done) begin
      dcnt_d = dcnt_q - 1'b1;
      case (dcnt_q)
        CNT_W'(3): dq_d = DIV_W'(mul_p[DIV_W+RCP_W-1:RCP_SH]);
        CNT_W'(2): dr_d = dx_q - mul_p[DIV_W-1:0];
        CNT_W'(1): begin
          if (dr_q >= DIV_W'(dvs_q)) begin
            dq_d = dq_q + 1'b1;
            dr_d = dr_q - DIV_W'(dvs_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d; dq_q <= dq_d; dr_q <= dr_d; dvs_q <= dvs_d; rcp_q <= rcp_d;
    op_q <= op_d; d1_q <= d1_d; m1_q <= m1_d; y1_q <= y1_d;
    d2_q <= d2_d; m2_q <= m2_d; y2_q <= y2_d; off_q <= off_d;
    s1_q <= s1_d; s2_q <= s2_d; v1_q <= v1_d; v2_q <= v2_d; res_q <= res_d;
    era_q <= era_d; doe_q <= doe_d; a_q <= a_d; yoe_q <= yoe_d; doy_q <= doy_d;
    rday_q <= rday_d; rmon_q <= rmon_d; ryear_q <= ryear_d;
    tot_q <= tot_d; wday_q <= wday_d; stat_q <= stat_d;
  end

  // outputs
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    m_axis_tvalid = (state_q == S_OUT);
    m_axis_tdata  = {wday_q, tot_q, ryear_q, rmon_q, rday_q};
    m_axis_tuser  = stat_q;
  end

endmodule

/* dv/gdau_checker.sv */
// Checker for the Gregorian date arithmetic unit: watches both stream channels,
// predicts each result item from the accepted input item and compares.
// Depends on gdau_pkg.
`timescale 1ns / 100ps

module gdau_checker
  import gdau_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic [3:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  weekday;
    logic [21:0] total;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_result_t;

  date_result_t result_q[$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  function automatic bit is_leap(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic bit date_valid(longint d, longint m, longint y);
    longint lim;
    if (y > MAX_YEAR_DEF || m < 1 || m > 12) return 0;
    lim = MDAYS[m - 1];
    if (m == 2 && is_leap(y)) lim = 29;
    return d >= 1 && d <= lim;
  endfunction

  // serial 0 is 1 March of year 0
  function automatic longint day_serial(longint d, longint m, longint y);
    longint mm, yy, sh;
    mm = (m + 9) % 12;
    yy = y - mm / 10;
    sh = yy + 400;
    return 365 * yy + sh / 4 - sh / 100 + sh / 400 - 97 + (mm * 306 + 5) / 10 + d - 1;
  endfunction

  function automatic void serial_to_date(longint s, output longint d, m, y);
    longint z, era, doe, yoe, doy, mp;
    z   = s + 146097;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    y   = yoe + era * 400 - 400;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = mp < 10 ? mp + 3 : mp - 9;
    if (m <= 2) y = y + 1;
  endfunction

  function automatic longint clip_total(longint v);
    if (v < 0) return 0;
    if (v > TOTAL_MAX) return TOTAL_MAX;
    return v;
  endfunction

  function automatic date_result_t predict_date(logic [3:0] op, logic [71:0] data);
    date_result_t r;
    longint d1, m1, y1, d2, m2, y2, off, s1, s2, smin, smax, res, rd, rm, ry;
    bit two, dated;
    r = '0;
    d1 = data[4:0];   m1 = data[8:5];   y1 = data[22:9];
    d2 = data[27:23]; m2 = data[31:28]; y2 = data[45:32];
    off = longint'($signed(data[68:46]));
    if (off < 0) off = -off;
    two   = op inside {OP_EARLIER, OP_DIFF, OP_ADDDATES, OP_SUBDATES};
    dated = op inside {OP_NEXT, OP_PREV, OP_ADD, OP_SUB, OP_EARLIER, OP_ADDDATES,
                       OP_SUBDATES};
    if (!date_valid(d1, m1, y1) || (two && !date_valid(d2, m2, y2))) begin
      r.status = ST_INVALID;
      return r;
    end
    s1 = day_serial(d1, m1, y1);
    s2 = two ? day_serial(d2, m2, y2) : s1;
    smin = s2 < s1 ? s2 : s1;
    smax = s2 > s1 ? s2 : s1;
    r.weekday = 3'((((s1 + 2) % 7) + 7) % 7);
    res = 0;
    case (op)
      OP_NEXT:     res = s1 + 1;
      OP_PREV:     res = s1 - 1;
      OP_ADD:      res = s1 + off;
      OP_SUB:      res = s1 - off;
      OP_EARLIER:  res = smin;
      OP_DIFF:     r.total = 22'(clip_total(smax - smin));
      OP_ORDINAL:  r.total = 22'(clip_total(s1 + 61));
      OP_ADDDATES: res = smax + smin + 61;
      OP_SUBDATES: res = smax - (smin + 61);
      default: ;
    endcase
    if (dated) begin
      if (res < day_serial(1, 1, 0) || res > day_serial(31, 12, MAX_YEAR_DEF)) begin
        r.status = ST_RANGE;
        return r;
      end
      serial_to_date(res, rd, rm, ry);
      r.day = 5'(rd); r.month = 4'(rm); r.year = 14'(ry);
    end
    r.status = ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk_i) begin
    date_result_t want, got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        result_q.push_back(predict_date(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (result_q.size() == 0) begin
          report_mismatch("unexpected item", got, 0);
        end else begin
          want = result_q.pop_front();
          if (got.day != want.day) report_mismatch("day", got.day, want.day);
          if (got.month != want.month) report_mismatch("month", got.month, want.month);
          if (got.year != want.year) report_mismatch("year", got.year, want.year);
          if (got.total != want.total) report_mismatch("day_total", got.total, want.total);
          if (got.weekday != want.weekday)
            report_mismatch("weekday", got.weekday, want.weekday);
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
        end
      end
    end
  end

endmodule

/* dv/tb_gregorian_date_arithmetic_unit.sv */
// Testbench top for the Gregorian date arithmetic unit: drives directed and
// random date items, random stalls, and gives the verdict.
// Depends on gdau_pkg and gdau_checker.
`timescale 1ns / 100ps

module tb_gregorian_date_arithmetic_unit;
  import gdau_pkg::*;

  localparam int NUM_RANDOM = 1800;
  localparam longint CYCLE_LIMIT = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: first_day first_month first_year second_day second_month second_year
  //        day_offset, zero pad
  logic [71:0] s_axis_tdata = '0;
  // tuser: operation
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: result_day result_month result_year day_total weekday
  logic [47:0] m_axis_tdata;
  // tuser: status
  logic [1:0]  m_axis_tuser;

  int  fail_count, pending;
  bit  hold_off = 0;
  longint cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gregorian_date_arithmetic_unit i_dut (.*);

  gdau_checker i_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  function automatic logic [71:0] pack_dates(int d1, m1, y1, d2, m2, y2, int off);
    logic [22:0] o;
    o = 23'(off);
    return {3'b0, o, y2[13:0], m2[3:0], d2[4:0], y1[13:0], m1[3:0], d1[4:0]};
  endfunction

  // valid stays up across items sent back to back
  task automatic send_item(logic [3:0] op, logic [71:0] data);
    int g;
    g = gap_len();
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // mostly plausible dates, sometimes anything the fields allow
  function automatic logic [71:0] random_dates();
    int d1, m1, y1, d2, m2, y2, off;
    m1 = $urandom_range(1, 12); d1 = $urandom_range(1, 28);
    m2 = $urandom_range(1, 12); d2 = $urandom_range(1, 28);
    y1 = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) * 2500 + $urandom_range(0, 4)
                                    : $urandom_range(0, 9999);
    y2 = $urandom_range(0, 9999);
    if ($urandom_range(0, 3) == 0) d1 = $urandom_range(29, 31);
    if ($urandom_range(0, 5) == 0) d2 = $urandom_range(29, 31);
    case ($urandom_range(0, 3))
      0: off = $urandom_range(0, 3) - 1;
      1: off = $signed($urandom_range(0, 2000)) - 1000;
      2: off = $signed($urandom_range(0, 8000000)) - 4000000;
      default: off = $urandom_range(0, 730000);
    endcase
    if ($urandom_range(0, 11) == 0) return {3'b0, 69'($urandom()) |
                                        (69'($urandom()) << 32) | (69'($urandom()) << 64)};
    return pack_dates(d1, m1, y1, d2, m2, y2, off);
  endfunction

  // receiver: random gaps plus one long hold-off
  initial begin
    int rx_gap;
    rx_gap = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off || rx_gap > 0) begin
        m_axis_tready <= 1'b0;
        if (rx_gap > 0) rx_gap--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_gap = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    logic [3:0] op;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, every operation, special cases
    send_item(OP_VALIDATE, pack_dates(29, 2, 0, 1, 1, 0, 0));
    send_item(OP_VALIDATE, pack_dates(29, 2, 1900, 1, 1, 0, 0));    // not leap
    send_item(OP_VALIDATE, pack_dates(31, 12, 9999, 1, 1, 0, 0));
    send_item(OP_VALIDATE, pack_dates(1, 1, 10000, 1, 1, 0, 0));    // year over max
    send_item(OP_VALIDATE, pack_dates(0, 0, 16383, 31, 15, 16383, 0));
    send_item(OP_NEXT, pack_dates(31, 12, 9999, 0, 0, 0, 0));       // out of range
    send_item(OP_NEXT, pack_dates(28, 2, 2000, 0, 0, 0, 0));
    send_item(OP_PREV, pack_dates(1, 1, 0, 0, 0, 0, 0));            // out of range
    send_item(OP_PREV, pack_dates(1, 3, 0, 0, 0, 0, 0));
    send_item(OP_ADD, pack_dates(1, 1, 0, 0, 0, 0, 4194303));
    send_item(OP_ADD, pack_dates(1, 1, 0, 0, 0, 0, -4194303));     // absolute value
    send_item(OP_ADD, pack_dates(15, 6, 2024, 0, 0, 0, -4194304));
    send_item(OP_SUB, pack_dates(31, 12, 9999, 0, 0, 0, 3652424));
    send_item(OP_SUB, pack_dates(31, 12, 9999, 0, 0, 0, -3652425));
    send_item(OP_EARLIER, pack_dates(5, 5, 2020, 5, 5, 2020, 0));  // equal dates
    send_item(OP_EARLIER, pack_dates(5, 5, 2020, 4, 5, 2020, 0));
    send_item(OP_EARLIER, pack_dates(5, 5, 2020, 31, 4, 2020, 0)); // invalid second
    send_item(OP_DIFF, pack_dates(1, 1, 0, 31, 12, 9999, 0));
    send_item(OP_ORDINAL, pack_dates(1, 1, 0, 0, 0, 0, 0));
    send_item(OP_ORDINAL, pack_dates(31, 12, 9999, 0, 0, 0, 0));
    send_item(OP_ADDDATES, pack_dates(1, 1, 5000, 1, 1, 6000, 0));
    send_item(OP_ADDDATES, pack_dates(1, 1, 1, 2, 1, 1, 0));
    send_item(OP_SUBDATES, pack_dates(1, 1, 0, 1, 1, 0, 0));       // out of range
    send_item(OP_SUBDATES, pack_dates(1, 1, 100, 1, 1, 9000, 0));
    send_item(4'd15, pack_dates(10, 10, 1000, 0, 0, 0, 0));         // unknown op
    n = 0;
    while (n < NUM_RANDOM) begin
      if (n == NUM_RANDOM / 2) begin
        // long hold-off: block holds its result and stalls its input
        fork
          begin
            hold_off = 1;
            repeat (800) @(posedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
      send_item(op, random_dates());
      n++;
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
design/gdau_pkg.sv
design/gregorian_date_arithmetic_unit.sv
dv/gdau_checker.sv
dv/tb_gregorian_date_arithmetic_unit.sv
